// ===== design/rsm_pkg.sv =====
// rsm_pkg: shared constants, item structs and helper functions for the
// rotation/scale matrix pipeline
// depends on nothing
package rsm_pkg;

	localparam int WORD_BITS    = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int FRAC         = WORD_BITS - 2;

	// widths
	localparam int XW        = FRAC + 4;   // cordic x/y
	localparam int ZW        = 34;         // cordic angle, q30
	localparam int VW        = 48;         // angle before reduction, q30 offset positive
	localparam int RED_STEPS = 14;         // restoring reduction steps mod two pi
	localparam int SCW       = 31;         // scale fields
	localparam int CSW       = 18;         // cos/sin, signed q2.16
	localparam int DATW      = 32;         // matrix entries
	localparam int QW        = 33;         // quotient bits
	localparam int REMW      = 32;         // remainder bits
	localparam int DIV_STEPS = QW;
	localparam int PW        = CSW + SCW + 1;  // product width
	localparam int STEPW     = 5;

	localparam int IN_W   = 96;
	localparam int OUT_W  = 296;

	// angle constants, q30
	localparam logic [VW-1:0]        TWO_PI_V   = 48'd6746518852;
	localparam logic [VW-1:0]        RED_OFFSET = 48'd55267482435584; // 8192 turns
	localparam logic signed [ZW-1:0] TWO_PI_Z   = 34'sd6746518852;
	localparam logic signed [ZW-1:0] PI_Z       = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Z  = 34'sd1686629713;
	localparam logic signed [63:0]   GAIN_Q30   = 64'sh26DD3B6A;

	localparam logic signed [19:0] ONE_Q16  = 20'sd65536;
	localparam logic signed [19:0] MONE_Q16 = -20'sd65536;

	localparam logic [DATW-1:0] INT_MAX = 32'h7FFF_FFFF;
	localparam logic [DATW-1:0] INT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [VW-1:0]  v;
		logic [SCW-1:0] sx;
		logic [SCW-1:0] sy;
		logic           last;
	} red_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg;
		logic [SCW-1:0]       sx;
		logic [SCW-1:0]       sy;
		logic                 last;
	} cord_t;

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [QW-1:0]   nq;
	} div_lane_t;

	typedef struct packed {
		logic signed [CSW-1:0]  c;
		logic signed [CSW-1:0]  s;
		logic [3:0][DATW-1:0]   fwd;
		logic                   fwd_ovf;
		logic [3:0]             neg;
		logic [3:0]             zero;
		logic                   last;
	} side_t;

	typedef struct packed {
		div_lane_t [3:0] lane;
		logic [SCW-1:0]  sx;
		logic [SCW-1:0]  sy;
		side_t           side;
	} div_t;

	// atan(2^-i), truncated q30
	function automatic logic signed [ZW-1:0] atan_q30(input logic [STEPW-1:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'h3243F6A8;
			5'd1:  a = 32'h1DAC6705;
			5'd2:  a = 32'h0FADBAFC;
			5'd3:  a = 32'h07F56EA6;
			5'd4:  a = 32'h03FEAB76;
			5'd5:  a = 32'h01FFD55B;
			5'd6:  a = 32'h00FFFAAA;
			5'd7:  a = 32'h007FFF55;
			5'd8:  a = 32'h003FFFEA;
			5'd9:  a = 32'h001FFFFD;
			5'd10: a = 32'h000FFFFF;
			5'd11: a = 32'h0007FFFF;
			5'd12: a = 32'h0003FFFF;
			5'd13: a = 32'h0001FFFF;
			5'd14: a = 32'h0000FFFF;
			5'd15: a = 32'h00007FFF;
			5'd16: a = 32'h00003FFF;
			5'd17: a = 32'h00001FFF;
			5'd18: a = 32'h00000FFF;
			5'd19: a = 32'h000007FF;
			5'd20: a = 32'h000003FF;
			5'd21: a = 32'h000001FF;
			5'd22: a = 32'h000000FF;
			5'd23: a = 32'h0000007F;
			5'd24: a = 32'h0000003F;
			5'd25: a = 32'h0000001F;
			5'd26: a = 32'h0000000F;
			5'd27: a = 32'h00000007;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return $signed({{(ZW-32){1'b0}}, a});
	endfunction

	// converged gain in FRAC fraction bits
	function automatic logic signed [XW-1:0] gain_init();
		logic signed [63:0] g;
		g = GAIN_Q30;
		if (FRAC >= 30)
			g = g <<< ((FRAC >= 30) ? FRAC - 30 : 0);
		else
			g = g >>> ((FRAC < 30) ? 30 - FRAC : 0);
		return g[XW-1:0];
	endfunction

	// FRAC fraction bits to q16, rounded half up, then clamped to [-1, 1]
	function automatic logic signed [19:0] to_q16_clamp(input logic signed [XW-1:0] x);
		logic signed [63:0] t;
		t = 64'(x);
		if (FRAC > 16) begin
			t = t + (64'sd1 <<< ((FRAC > 16) ? FRAC - 17 : 0));
			t = t >>> ((FRAC > 16) ? FRAC - 16 : 0);
		end else if (FRAC < 16) begin
			t = t <<< ((FRAC < 16) ? 16 - FRAC : 0);
		end
		if (t > 64'(ONE_Q16))
			return ONE_Q16;
		else if (t < 64'(MONE_Q16))
			return MONE_Q16;
		else
			return t[19:0];
	endfunction

endpackage

// ===== design/rsm_red_cell.sv =====
// rsm_red_cell: one restoring step of the angle reduction modulo two pi
// depends on rsm_pkg
module rsm_red_cell import rsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [3:0]  step,
	input  logic        in_valid,
	input  red_t        in_data,
	output logic        out_valid,
	output red_t        out_data
);

	logic [VW-1:0] m;
	red_t          nxt;

	assign m = TWO_PI_V << step;

	always_comb begin
		nxt = in_data;
		if (in_data.v >= m)
			nxt.v = in_data.v - m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			out_data <= nxt;
	end

endmodule

// ===== design/rsm_cordic_cell.sv =====
// rsm_cordic_cell: one rotation-mode cordic micro-rotation
// depends on rsm_pkg
module rsm_cordic_cell import rsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [STEPW-1:0] step,
	input  logic             in_valid,
	input  cord_t            in_data,
	output logic             out_valid,
	output cord_t            out_data
);

	logic signed [XW-1:0] dx, dy;
	logic signed [ZW-1:0] da;
	cord_t                nxt;

	assign dx = in_data.y >>> step;
	assign dy = in_data.x >>> step;
	assign da = atan_q30(step);

	always_comb begin
		nxt = in_data;
		if (!in_data.z[ZW-1]) begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - da;
		end else begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			out_data <= nxt;
	end

endmodule

// ===== design/rsm_div_cell.sv =====
// rsm_div_cell: one restoring quotient bit for the four inverse lanes
// depends on rsm_pkg
module rsm_div_cell import rsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  div_t  in_data,
	output logic  out_valid,
	output div_t  out_data
);

	div_t nxt;

	always_comb begin
		logic [REMW-1:0] t;
		logic [REMW-1:0] d;
		logic            ge;
		nxt = in_data;
		for (int k = 0; k < 4; k++) begin
			// lanes 0 and 1 divide by scale_x, 2 and 3 by scale_y
			d  = (k < 2) ? {1'b0, in_data.sx} : {1'b0, in_data.sy};
			t  = {in_data.lane[k].rem[REMW-2:0], in_data.lane[k].nq[QW-1]};
			ge = (t >= d);
			nxt.lane[k].rem = ge ? t - d : t;
			nxt.lane[k].nq  = {in_data.lane[k].nq[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			out_data <= nxt;
	end

endmodule

// ===== design/rotation_scale_matrix_2d_top.sv =====
// rotation_scale_matrix_2d_top: streaming rotation and scale-rotation matrix unit
// depends on rsm_pkg, rsm_red_cell, rsm_cordic_cell, rsm_div_cell
//
// Each input item carries one body: an angle (signed q16.16 radians) and two
// nonnegative q15.16 scales. The block returns cos, sin, the scale-rotation
// matrix {cos*sx, -sin*sy; sin*sx, cos*sy} and its inverse
// {cos/sx, sin/sx; -sin/sy, cos/sy}, each matrix entry saturating to 32 bits,
// with tuser raised when any entry saturated or a scale was zero. The datapath
// is a row of cells: 14 reduction cells take the angle modulo two pi, 16 cordic
// cells find cos and sin, and 33 divider cells produce one quotient bit each
// for the four inverse entries. A new item is taken every cycle while the
// output side does not stall; the divider row is the longest part of the row.
// The whole row advances together whenever the output register is empty or
// being taken, so s_tready follows m_tready while a result waits. No clearing
// pass is needed after reset.
module rotation_scale_matrix_2d_top import rsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // angle[31:0], scale_x[62:32], scale_y[93:63], zero pad
	input  logic             s_tlast,   // last_body
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // cos_val, sin_val, fwd_00..fwd_11, inv_00..inv_11, zero pad
	output logic             m_tuser,   // overflow_flag
	output logic             m_tlast    // last_out
);

	logic en;

	// whole chain moves when the output register can take a new item
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// entry stage: angle to q30, offset positive by a whole number of turns
	logic v_s1;
	red_t red_s1;
	logic signed [VW-1:0] ang_ext;

	assign ang_ext = VW'($signed(s_tdata[31:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1.v    <= (ang_ext <<< 14) + RED_OFFSET;
			red_s1.sx   <= s_tdata[62:32];
			red_s1.sy   <= s_tdata[93:63];
			red_s1.last <= s_tlast;
		end
	end

	// reduction row, largest multiple of two pi first
	logic red_v [0:RED_STEPS];
	red_t red_d [0:RED_STEPS];

	assign red_v[0] = v_s1;
	assign red_d[0] = red_s1;

	for (genvar i = 0; i < RED_STEPS; i++) begin : g_red
		rsm_red_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (4'(RED_STEPS - 1 - i)),
			.in_valid  (red_v[i]),
			.in_data   (red_d[i]),
			.out_valid (red_v[i+1]),
			.out_data  (red_d[i+1])
		);
	end

	// fold stage: into [-pi, pi], then into [-pi/2, pi/2] with a sign flip
	logic  v_s2;
	cord_t cord_s2;
	cord_t fold;

	always_comb begin
		logic signed [ZW-1:0] z;
		z = $signed(red_d[RED_STEPS].v[ZW-1:0]);
		if (z > PI_Z)
			z = z - TWO_PI_Z;
		fold.neg = 1'b0;
		if (z > HALF_PI_Z) begin
			z        = z - PI_Z;
			fold.neg = 1'b1;
		end else if (z < -HALF_PI_Z) begin
			z        = z + PI_Z;
			fold.neg = 1'b1;
		end
		fold.z    = z;
		fold.x    = gain_init();
		fold.y    = '0;
		fold.sx   = red_d[RED_STEPS].sx;
		fold.sy   = red_d[RED_STEPS].sy;
		fold.last = red_d[RED_STEPS].last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= red_v[RED_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			cord_s2 <= fold;
	end

	// cordic row
	logic  cord_v [0:CORDIC_STEPS];
	cord_t cord_d [0:CORDIC_STEPS];

	assign cord_v[0] = v_s2;
	assign cord_d[0] = cord_s2;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		rsm_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (STEPW'(i)),
			.in_valid  (cord_v[i]),
			.in_data   (cord_d[i]),
			.out_valid (cord_v[i+1]),
			.out_data  (cord_d[i+1])
		);
	end

	// finish stage: round to q16, clamp, undo the fold
	logic                  v_s3;
	logic signed [CSW-1:0] c_s3, s_s3;
	logic [SCW-1:0]        sx_s3, sy_s3;
	logic                  last_s3;
	logic signed [19:0]    c_r, s_r;

	assign c_r = to_q16_clamp(cord_d[CORDIC_STEPS].x);
	assign s_r = to_q16_clamp(cord_d[CORDIC_STEPS].y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= cord_v[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3    <= cord_d[CORDIC_STEPS].neg ? -c_r[CSW-1:0] : c_r[CSW-1:0];
			s_s3    <= cord_d[CORDIC_STEPS].neg ? -s_r[CSW-1:0] : s_r[CSW-1:0];
			sx_s3   <= cord_d[CORDIC_STEPS].sx;
			sy_s3   <= cord_d[CORDIC_STEPS].sy;
			last_s3 <= cord_d[CORDIC_STEPS].last;
		end
	end

	// multiply stage: the four forward products
	logic                       v_s4;
	logic signed [3:0][PW-1:0]  p_s4;
	logic signed [CSW-1:0]      c_s4, s_s4;
	logic [SCW-1:0]             sx_s4, sy_s4;
	logic                       last_s4;
	logic signed [CSW-1:0]      ns_s3;

	assign ns_s3 = -s_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4[0] <= PW'(c_s3) * PW'($signed({1'b0, sx_s3}));
			p_s4[1] <= PW'(ns_s3) * PW'($signed({1'b0, sy_s3}));
			p_s4[2] <= PW'(s_s3) * PW'($signed({1'b0, sx_s3}));
			p_s4[3] <= PW'(c_s3) * PW'($signed({1'b0, sy_s3}));
			c_s4    <= c_s3;
			s_s4    <= s_s3;
			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;
			last_s4 <= last_s3;
		end
	end

	// round and saturate the forward entries, load the divider lanes
	div_t div_init;

	always_comb begin
		logic signed [PW-1:0]  r;
		logic [CSW-1:0]        mag_c, mag_s;
		div_init.side.fwd_ovf = 1'b0;
		for (int k = 0; k < 4; k++) begin
			r = ($signed(p_s4[k]) + PW'(32768)) >>> 16;
			if (r > $signed(PW'(INT_MAX))) begin
				div_init.side.fwd[k]  = INT_MAX;
				div_init.side.fwd_ovf = 1'b1;
			end else if (r < -$signed(PW'({1'b0, INT_MIN}))) begin
				div_init.side.fwd[k]  = INT_MIN;
				div_init.side.fwd_ovf = 1'b1;
			end else begin
				div_init.side.fwd[k]  = r[DATW-1:0];
			end
		end
		mag_c = c_s4[CSW-1] ? -c_s4 : c_s4;
		mag_s = s_s4[CSW-1] ? -s_s4 : s_s4;
		// magnitudes of value * 2^16
		div_init.lane[0].nq  = {mag_c[16:0], 16'd0};
		div_init.lane[1].nq  = {mag_s[16:0], 16'd0};
		div_init.lane[2].nq  = {mag_s[16:0], 16'd0};
		div_init.lane[3].nq  = {mag_c[16:0], 16'd0};
		for (int k = 0; k < 4; k++)
			div_init.lane[k].rem = '0;
		div_init.side.neg[0]  = c_s4[CSW-1];
		div_init.side.neg[1]  = s_s4[CSW-1];
		div_init.side.neg[2]  = !s_s4[CSW-1] && (s_s4 != '0);
		div_init.side.neg[3]  = c_s4[CSW-1];
		div_init.side.zero[0] = (sx_s4 == '0);
		div_init.side.zero[1] = (sx_s4 == '0);
		div_init.side.zero[2] = (sy_s4 == '0);
		div_init.side.zero[3] = (sy_s4 == '0);
		div_init.side.c       = c_s4;
		div_init.side.s       = s_s4;
		div_init.side.last    = last_s4;
		div_init.sx           = sx_s4;
		div_init.sy           = sy_s4;
	end

	// divider row, one quotient bit per cell
	logic div_v [0:DIV_STEPS];
	div_t div_d [0:DIV_STEPS];

	assign div_v[0] = v_s4;
	assign div_d[0] = div_init;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		rsm_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (div_v[i]),
			.in_data   (div_d[i]),
			.out_valid (div_v[i+1]),
			.out_data  (div_d[i+1])
		);
	end

	// output stage: sign, saturation, zero-scale cases, overflow flag
	logic [3:0][DATW-1:0] inv;
	logic                 flag;
	side_t                sd;

	assign sd = div_d[DIV_STEPS].side;

	always_comb begin
		logic [QW-1:0] q;
		flag = sd.fwd_ovf;
		for (int k = 0; k < 4; k++) begin
			q = div_d[DIV_STEPS].lane[k].nq;
			if (sd.zero[k]) begin
				inv[k] = sd.neg[k] ? INT_MIN : INT_MAX;
				flag   = 1'b1;
			end else if (sd.neg[k]) begin
				if (q > {1'b0, INT_MIN}) begin
					inv[k] = INT_MIN;
					flag   = 1'b1;
				end else begin
					inv[k] = -q[DATW-1:0];
				end
			end else begin
				if (q > {1'b0, INT_MAX}) begin
					inv[k] = INT_MAX;
					flag   = 1'b1;
				end else begin
					inv[k] = q[DATW-1:0];
				end
			end
		end
	end

	logic                  out_v_q;
	logic signed [CSW-1:0] cos_q, sin_q;
	logic [3:0][DATW-1:0]  fwd_q, inv_q;
	logic                  flag_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= div_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q  <= sd.c;
			sin_q  <= sd.s;
			fwd_q  <= sd.fwd;
			inv_q  <= inv;
			flag_q <= flag;
			last_q <= sd.last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, inv_q[3], inv_q[2], inv_q[1], inv_q[0],
	                   fwd_q[3], fwd_q[2], fwd_q[1], fwd_q[0], sin_q, cos_q};
	assign m_tuser  = flag_q;
	assign m_tlast  = last_q;

	// cos and sin never leave [-1, 1]
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(cos_q) <= 18'sd65536 && $signed(cos_q) >= -18'sd65536))
		else $error("cos out of range");

	a_sin_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(sin_q) <= 18'sd65536 && $signed(sin_q) >= -18'sd65536))
		else $error("sin out of range");

	// an empty or draining output register never blocks the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with free output");

	// a stalled chain keeps its result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(flag_q) && $stable(last_q)))
		else $error("result lost under stall");

endmodule
